[rtl/core/array_list_insert_search_delete_defines.svh]
// Assertion macros used by the list block's sequencer.
`ifndef ARRAY_LIST_INSERT_SEARCH_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_SEARCH_DELETE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ALST_ASSERT_INV(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("list invariant violated");

// A condition that must hold in the same cycle as its trigger.
`define ALST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list implication violated");

// A condition that must hold in the cycle after its trigger.
`define ALST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list sequence violated");

`endif

[rtl/core/alst_pkg.sv]
// Types and codes shared by the list block's modules.
package alst_pkg;

    typedef logic signed [31:0] t_key;
    typedef logic [1:0]         t_kind;
    typedef logic [1:0]         t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_MISSING = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

endpackage

[rtl/core/alst_mem.sv]
// Key store: one write port and one read port with registered read data.
module alst_mem
    import alst_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_key          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_key          o_rdata
);

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/alst_seq.sv]
// Sequencer: scans, shifts and counts the list one entry per cycle.
`include "array_list_insert_search_delete_defines.svh"

module alst_seq
    import alst_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_kind         i_kind,
    input  t_key          i_key,
    output logic          o_busy,
    output logic          o_done,
    output t_status       o_status,
    output logic [CW-1:0] o_count,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_key          o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  t_key          i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_SHDN = 4'b0100,
        S_SHUP = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic          r_is_del, n_is_del;
    t_key          r_key, n_key;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_cidx, n_cidx;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_count, n_count;
    logic          r_done, n_done;
    t_status       r_status, n_status;

    logic          w_hit;
    logic [CW-1:0] w_ptr_dec;

    // r_pend says that i_rdata holds the entry at r_cidx, read in the previous cycle.
    assign w_hit     = r_pend && (i_rdata == r_key);
    assign w_ptr_dec = r_ptr - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_is_del = r_is_del;
        n_key    = r_key;
        n_ptr    = r_ptr;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_count  = r_count;
        n_done   = 1'b0;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = r_key;
        o_re     = 1'b0;
        o_raddr  = r_ptr[AW-1:0];

        case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_start) begin
                    n_key = i_key;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                // r_ptr counts the entries still to be moved back.
                                n_ptr   = r_count;
                                n_state = S_SHUP;
                            end
                        end
                        KIND_DELETE: begin
                            n_is_del = 1'b1;
                            n_ptr    = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_is_del = 1'b0;
                            n_ptr    = '0;
                            n_state  = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_hit) begin
                    n_pend = 1'b0;
                    if (r_is_del) begin
                        n_ptr   = CW'(r_cidx) + CW'(1);
                        n_state = S_SHDN;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_DONE;
                        n_state  = S_IDLE;
                    end
                end else if (r_ptr < r_count) begin
                    o_re   = 1'b1;
                    n_pend = 1'b1;
                    n_cidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_pend   = 1'b0;
                    n_done   = 1'b1;
                    n_status = ST_MISSING;
                    n_state  = S_IDLE;
                end
            end

            S_SHDN: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_cidx - AW'(1);
                    o_wdata = i_rdata;
                end
                if (r_ptr < r_count) begin
                    o_re   = 1'b1;
                    n_pend = 1'b1;
                    n_cidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - CW'(1);
                        n_done   = 1'b1;
                        n_status = ST_DONE;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_SHUP: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_cidx + AW'(1);
                    o_wdata = i_rdata;
                end
                if (r_ptr != '0) begin
                    o_re    = 1'b1;
                    o_raddr = w_ptr_dec[AW-1:0];
                    n_pend  = 1'b1;
                    n_cidx  = w_ptr_dec[AW-1:0];
                    n_ptr   = w_ptr_dec;
                end else begin
                    n_pend = 1'b0;
                    // The head is written only once the last shifted entry has landed.
                    if (!r_pend) begin
                        o_we     = 1'b1;
                        o_waddr  = '0;
                        o_wdata  = r_key;
                        n_count  = r_count + CW'(1);
                        n_done   = 1'b1;
                        n_status = ST_DONE;
                        n_state  = S_IDLE;
                    end
                end
            end

            default: begin
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_del <= n_is_del;
        r_key    <= n_key;
        r_ptr    <= n_ptr;
        r_cidx   <= n_cidx;
        r_status <= n_status;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_count  = r_count;

    `ALST_ASSERT_INV(a_count_range, r_count <= CW'(CAPACITY))
    `ALST_ASSERT_IMP(a_done_idle, r_done, r_state == S_IDLE)
    `ALST_ASSERT_IMP(a_full_status, r_done && (r_status == ST_FULL), r_count == CW'(CAPACITY))
    `ALST_ASSERT_IMP(a_idle_no_read, r_state == S_IDLE, !r_pend)

endmodule

[rtl/core/array_list_insert_search_delete.sv]
// Top level of the array-backed list with head insert, search and delete.
//
// A request is taken on a rising edge with i_start high and o_busy low; it
// carries i_kind (insert at head, delete first match, search; either spare code
// searches) and the 32-bit key i_key. Every request gives one result:
// o_done is high for exactly one cycle with o_status (done or found, not
// found, list full) and o_count_after, the number of keys held afterwards
// (low five bits). The receiver cannot stall, so the result is valid only in
// that strobe cycle. o_busy falls in the cycle the strobe rises, so a new
// request may be taken then.
// An insert moves each held key up one place, then writes the new key at the
// head; an insert into a full list moves nothing. A search scans from the
// head to the first match; a delete scans to the match, then closes the gap.
// The key store's single port pair moves or compares one entry per cycle.
// Reset empties the list; the store itself is not cleared, as only
// positions below the count are ever read.
module array_list_insert_search_delete
    import alst_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_kind   i_kind,
    input  t_key    i_key,
    output logic    o_busy,
    output logic    o_done,
    output t_status o_status,
    output logic [4:0] o_count_after
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_key          w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_key          w_rdata;
    logic [CW-1:0] w_count;

    alst_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_kind   (i_kind),
        .i_key    (i_key),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_status (o_status),
        .o_count  (w_count),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    alst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_count_after = 5'(w_count);

endmodule
